// ===== sv/sigmoid_attraction_force_defines.svh =====
// ----------------------------------------------------------------------------
// sigmoid attraction force assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SIGMOID_ATTRACTION_FORCE_DEFINES_SVH
`define SIGMOID_ATTRACTION_FORCE_DEFINES_SVH

// same-cycle implication
`define SAF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/saf_pkg.sv =====
// ----------------------------------------------------------------------------
// saf_pkg
// shared types, constants and exp tables of the attraction force pipeline
// ----------------------------------------------------------------------------
package saf_pkg;

    localparam int DIM        = 4;
    localparam int ROOT_STEPS = 32;
    localparam int SIG_STEPS  = 17;
    localparam int FDIV_STEPS = 32;

    localparam logic [15:0] SCALE_RESET = 16'd256;
    localparam logic [20:0] X_CAP       = 21'h100000;
    localparam logic [4:0]  EXP_INT_N   = 5'd12;

    localparam logic [16:0] EXP_INT [0:11] = '{
        17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
        17'd162,   17'd60,    17'd22,   17'd8,    17'd3,    17'd1
    };

    localparam logic [16:0] EXP_FRAC [0:16] = '{
        17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947,
        17'd45042, 17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954,
        17'd30957, 17'd29081, 17'd27319, 17'd25664, 17'd24109
    };

    typedef struct packed {
        logic                  degen;
        logic                  k;
        logic [DIM-1:0]        neg;
        logic [DIM-1:0][31:0]  mag;
        logic [31:0]           w;
        logic [15:0]           edges;
        logic [15:0]           nodes;
    } edge_t;

    typedef struct packed {
        edge_t       e;
        logic [32:0] n;
        logic [31:0] a;
    } root_t;

    typedef struct packed {
        edge_t       e;
        logic [32:0] n;
        logic [31:0] t;
    } gain_t;

    typedef struct packed {
        logic                 degen;
        logic [DIM-1:0][31:0] frc;
    } force_t;

endpackage

// ===== sv/sigmoid_attraction_force.sv =====
// ----------------------------------------------------------------------------
// sigmoid_attraction_force
// streaming graph-embedding attraction kernel with sigmoid edge gain
// ----------------------------------------------------------------------------
// Takes one request per clock while s_tready is high and returns one result
// per request, in order, through 3 front stages, 32 square-root stages (one
// root bit each, the weight division beside them), 23 sigmoid stages (17 of
// them the reciprocal divider), 32 stages of the gain and direction dividers
// and 2 stages of product and saturation. The whole pipeline advances while
// the output register is empty or being taken, else it holds and s_tready
// falls. sigmoid_scale is written through cfg_wen/cfg_wdata.
// ----------------------------------------------------------------------------
module sigmoid_attraction_force (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_v_x0..x3, pos_u_x0..x3, inv_weight_sum, edge_count, node_count_v
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x0..x3
    output logic [127:0] m_tdata,
    // degenerate
    output logic         m_tuser,
    input  logic         cfg_wen,
    input  logic [15:0]  cfg_wdata
);
    import saf_pkg::*;

    logic                 en;
    logic [15:0]          scale_reg;
    logic [DIM-1:0][31:0] pos_v;
    logic [DIM-1:0][31:0] pos_u;
    logic                 front_valid;
    edge_t                front_edge;
    logic [63:0]          front_sumsq;
    logic                 root_valid;
    root_t                root_data;
    logic                 sig_valid;
    gain_t                sig_gain;
    force_t               frc_out;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wen)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    for (genvar g = 0; g < DIM; g++)
    begin : g_unpack
        assign pos_v[g] = s_tdata[32*g +: 32];
        assign pos_u[g] = s_tdata[128 + 32*g +: 32];
    end

    saf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .pos_v     (pos_v),
        .pos_u     (pos_u),
        .w         (s_tdata[287:256]),
        .edges     (s_tdata[303:288]),
        .nodes     (s_tdata[319:304]),
        .out_valid (front_valid),
        .out_edge  (front_edge),
        .out_sumsq (front_sumsq)
    );

    saf_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_edge   (front_edge),
        .in_sumsq  (front_sumsq),
        .out_valid (root_valid),
        .out_root  (root_data)
    );

    saf_sigmoid u_sigmoid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .in_root   (root_data),
        .scale     (scale_reg),
        .out_valid (sig_valid),
        .out_gain  (sig_gain)
    );

    saf_force u_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sig_valid),
        .in_gain   (sig_gain),
        .out_valid (m_tvalid),
        .out_force (frc_out)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_pack
        if (g < DIM)
        begin : g_used
            assign m_tdata[32*g +: 32] = frc_out.frc[g];
        end
        else
        begin : g_unused
            assign m_tdata[32*g +: 32] = '0;
        end
    end

    assign m_tuser = frc_out.degen;

endmodule

// ===== sv/saf_front.sv =====
// ----------------------------------------------------------------------------
// saf_front
// difference, magnitude, prescale and sum of squares of the two positions
// ----------------------------------------------------------------------------
module saf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [saf_pkg::DIM-1:0][31:0]     pos_v,
    input  logic [saf_pkg::DIM-1:0][31:0]     pos_u,
    input  logic [31:0]                       w,
    input  logic [15:0]                       edges,
    input  logic [15:0]                       nodes,
    output logic                              out_valid,
    output saf_pkg::edge_t                    out_edge,
    output logic [63:0]                       out_sumsq
);
    import saf_pkg::*;

    typedef struct packed {
        edge_t                e;
        logic [DIM-1:0][63:0] sq;
    } sq_stage_t;

    logic [2:0] vld_reg;
    edge_t      a_next;
    edge_t      a_reg;
    sq_stage_t  b_next;
    sq_stage_t  b_reg;
    edge_t      c_reg;
    logic [63:0] sum_next;
    logic [63:0] sum_reg;

    always_comb
    begin
        logic [32:0] d;
        logic [32:0] dm;
        a_next = '0;
        for (int i = 0; i < DIM; i++)
        begin
            d  = {pos_u[i][31], pos_u[i]} - {pos_v[i][31], pos_v[i]};
            dm = d[32] ? (~d + 33'd1) : d;
            a_next.neg[i] = d[32];
            a_next.mag[i] = dm[31:0];
            if (dm[31])
            begin
                a_next.k = 1'b1;
            end
        end
        a_next.degen = ~(|a_next.mag);
        a_next.w     = w;
        a_next.edges = (edges == 16'd0) ? 16'd1 : edges;
        a_next.nodes = (nodes == 16'd0) ? 16'd1 : nodes;
    end

    always_comb
    begin
        logic [31:0] t;
        b_next.e = a_reg;
        for (int i = 0; i < DIM; i++)
        begin
            t = a_reg.k ? {1'b0, a_reg.mag[i][31:1]} : a_reg.mag[i];
            b_next.sq[i] = {32'd0, t} * {32'd0, t};
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < DIM; i++)
        begin
            sum_next = sum_next + b_reg.sq[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= b_reg.e;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_edge  = c_reg;
    assign out_sumsq = sum_reg;

endmodule

// ===== sv/saf_root.sv =====
// ----------------------------------------------------------------------------
// saf_root
// pipelined integer square root of the sum of squares, one result bit per
// stage, with the average weight division running alongside
// ----------------------------------------------------------------------------
module saf_root (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  saf_pkg::edge_t in_edge,
    input  logic [63:0]    in_sumsq,
    output logic           out_valid,
    output saf_pkg::root_t out_root
);
    import saf_pkg::*;

    typedef struct packed {
        edge_t       e;
        logic [63:0] v;
        logic [63:0] res;
        logic [31:0] dvd;
        logic [15:0] arem;
        logic [31:0] aq;
    } root_stage_t;

    function automatic root_stage_t root_step(root_stage_t p, int idx);
        root_stage_t q;
        logic [63:0] bitv;
        logic [63:0] trial;
        logic [16:0] rsh;
        q     = p;
        bitv  = 64'd1 << (62 - 2 * idx);
        trial = p.res + bitv;
        if (p.v >= trial)
        begin
            q.v   = p.v - trial;
            q.res = (p.res >> 1) + bitv;
        end
        else
        begin
            q.res = p.res >> 1;
        end
        rsh   = {p.arem, p.dvd[31]};
        q.dvd = {p.dvd[30:0], 1'b0};
        if (rsh >= {1'b0, p.e.edges})
        begin
            q.arem = 16'(rsh - {1'b0, p.e.edges});
            q.aq   = {p.aq[30:0], 1'b1};
        end
        else
        begin
            q.arem = rsh[15:0];
            q.aq   = {p.aq[30:0], 1'b0};
        end
        return q;
    endfunction

    root_stage_t             stage_in;
    root_stage_t             stage_reg [0:ROOT_STEPS-1];
    logic [ROOT_STEPS-1:0]   vld_reg;
    root_stage_t             last;

    always_comb
    begin
        stage_in      = '0;
        stage_in.e    = in_edge;
        stage_in.v    = in_sumsq;
        stage_in.dvd  = in_edge.w;
    end

    for (genvar g = 0; g < ROOT_STEPS; g++)
    begin : g_step
        root_stage_t stage_next;
        if (g == 0)
        begin : g_first
            assign stage_next = root_step(stage_in, g);
        end
        else
        begin : g_rest
            assign stage_next = root_step(stage_reg[g-1], g);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[g] <= stage_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_STEPS-2:0], in_valid};
        end
    end

    assign last       = stage_reg[ROOT_STEPS-1];
    assign out_valid  = vld_reg[ROOT_STEPS-1];
    assign out_root.e = last.e;
    assign out_root.n = last.e.k ? {last.res[31:0], 1'b0} : {1'b0, last.res[31:0]};
    assign out_root.a = last.aq;

endmodule

// ===== sv/saf_sigmoid.sv =====
// ----------------------------------------------------------------------------
// saf_sigmoid
// sigmoid argument, table exp, pipelined reciprocal and weight product
// ----------------------------------------------------------------------------
module saf_sigmoid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  saf_pkg::root_t in_root,
    input  logic [15:0]    scale,
    output logic           out_valid,
    output saf_pkg::gain_t out_gain
);
    import saf_pkg::*;

    localparam int NSTG = SIG_STEPS + 6;

    typedef struct packed {
        edge_t       e;
        logic [32:0] n;
        logic        z;
        logic [48:0] pl;
        logic [48:0] ph;
    } x1_t;

    typedef struct packed {
        edge_t       e;
        logic [32:0] n;
        logic        z;
        logic        ovf;
        logic [47:0] p;
    } x2_t;

    typedef struct packed {
        edge_t       e;
        logic [32:0] n;
        logic [20:0] x;
    } x3_t;

    typedef struct packed {
        edge_t       e;
        logic [32:0] n;
        logic [16:0] eint;
        logic [16:0] ef;
    } x4_t;

    typedef struct packed {
        edge_t       e;
        logic [32:0] n;
        logic [17:0] den;
        logic [16:0] rem;
        logic [16:0] q;
    } sdiv_t;

    function automatic sdiv_t sdiv_step(sdiv_t p);
        sdiv_t       q;
        logic [17:0] rsh;
        q   = p;
        rsh = {p.rem, 1'b0};
        if (rsh >= p.den)
        begin
            q.rem = 17'(rsh - p.den);
            q.q   = {p.q[15:0], 1'b1};
        end
        else
        begin
            q.rem = rsh[16:0];
            q.q   = {p.q[15:0], 1'b0};
        end
        return q;
    endfunction

    logic [NSTG-1:0] vld_reg;
    x1_t   x1_next, x1_reg;
    x2_t   x2_next, x2_reg;
    x3_t   x3_next, x3_reg;
    x4_t   x4_next, x4_reg;
    sdiv_t x5_next, x5_reg;
    sdiv_t sd_reg [0:SIG_STEPS-1];
    gain_t g_next, g_reg;

    always_comb
    begin
        x1_next.e  = in_root.e;
        x1_next.n  = in_root.n;
        x1_next.z  = (scale == 16'd0) || (in_root.a == 32'd0) || (in_root.n == 33'd0);
        x1_next.pl = {16'd0, in_root.n} * {33'd0, in_root.a[15:0]};
        x1_next.ph = {16'd0, in_root.n} * {33'd0, in_root.a[31:16]};
    end

    always_comb
    begin
        logic [64:0] prod;
        prod        = {16'd0, x1_reg.pl} + {x1_reg.ph, 16'd0};
        x2_next.e   = x1_reg.e;
        x2_next.n   = x1_reg.n;
        x2_next.z   = x1_reg.z;
        x2_next.ovf = prod[64];
        x2_next.p   = prod[63:16];
    end

    always_comb
    begin
        logic [63:0] px;
        logic [55:0] xw;
        px        = {16'd0, x2_reg.p} * {48'd0, scale};
        xw        = px[63:8];
        x3_next.e = x2_reg.e;
        x3_next.n = x2_reg.n;
        if (x2_reg.z)
        begin
            x3_next.x = '0;
        end
        else if (x2_reg.ovf || (xw > {35'd0, X_CAP}))
        begin
            x3_next.x = X_CAP;
        end
        else
        begin
            x3_next.x = xw[20:0];
        end
    end

    always_comb
    begin
        logic [4:0]  xi;
        logic [4:0]  j;
        logic [16:0] fj;
        logic [16:0] fj1;
        logic [16:0] dlt;
        logic [27:0] pr;
        xi  = x3_reg.x[20:16];
        j   = {1'b0, x3_reg.x[15:12]};
        fj  = EXP_FRAC[j];
        fj1 = EXP_FRAC[j + 5'd1];
        dlt = fj - fj1;
        pr  = {12'd0, dlt[15:0]} * {16'd0, x3_reg.x[11:0]};
        x4_next.e  = x3_reg.e;
        x4_next.n  = x3_reg.n;
        x4_next.ef = fj - {1'b0, pr[27:12]};
        if (xi < EXP_INT_N)
        begin
            x4_next.eint = EXP_INT[xi[3:0]];
        end
        else
        begin
            x4_next.eint = '0;
        end
    end

    always_comb
    begin
        logic [33:0] ep;
        ep          = {17'd0, x4_reg.eint} * {17'd0, x4_reg.ef};
        x5_next.e   = x4_reg.e;
        x5_next.n   = x4_reg.n;
        x5_next.den = 18'd65536 + {1'b0, ep[32:16]};
        x5_next.rem = 17'h08000;
        x5_next.q   = '0;
    end

    for (genvar g = 0; g < SIG_STEPS; g++)
    begin : g_step
        sdiv_t sd_next;
        if (g == 0)
        begin : g_first
            assign sd_next = sdiv_step(x5_reg);
        end
        else
        begin : g_rest
            assign sd_next = sdiv_step(sd_reg[g-1]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_reg[g] <= sd_next;
            end
        end
    end

    always_comb
    begin
        logic [48:0] sw;
        sw       = {32'd0, sd_reg[SIG_STEPS-1].q} * {17'd0, sd_reg[SIG_STEPS-1].e.w};
        g_next.e = sd_reg[SIG_STEPS-1].e;
        g_next.n = sd_reg[SIG_STEPS-1].n;
        g_next.t = sw[47:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            x3_reg <= x3_next;
            x4_reg <= x4_next;
            x5_reg <= x5_next;
            g_reg  <= g_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_gain  = g_reg;

endmodule

// ===== sv/saf_force.sv =====
// ----------------------------------------------------------------------------
// saf_force
// pipelined gain and direction divisions, final product and saturation
// ----------------------------------------------------------------------------
module saf_force (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  saf_pkg::gain_t  in_gain,
    output logic            out_valid,
    output saf_pkg::force_t out_force
);
    import saf_pkg::*;

    localparam int NSTG = FDIV_STEPS + 2;

    typedef struct packed {
        edge_t                e;
        logic [32:0]          n;
        logic [31:0]          tdv;
        logic [15:0]          hrem;
        logic [31:0]          hq;
        logic [DIM-1:0][31:0] rdv;
        logic [DIM-1:0][32:0] rrem;
        logic [DIM-1:0][31:0] rq;
    } fdiv_t;

    typedef struct packed {
        logic                 degen;
        logic [DIM-1:0]       neg;
        logic [DIM-1:0][33:0] mag;
    } fmul_t;

    function automatic fdiv_t fdiv_step(fdiv_t p);
        fdiv_t       q;
        logic [16:0] hsh;
        logic [33:0] rsh;
        q     = p;
        hsh   = {p.hrem, p.tdv[31]};
        q.tdv = {p.tdv[30:0], 1'b0};
        if (hsh >= {1'b0, p.e.nodes})
        begin
            q.hrem = 16'(hsh - {1'b0, p.e.nodes});
            q.hq   = {p.hq[30:0], 1'b1};
        end
        else
        begin
            q.hrem = hsh[15:0];
            q.hq   = {p.hq[30:0], 1'b0};
        end
        for (int i = 0; i < DIM; i++)
        begin
            rsh      = {p.rrem[i], p.rdv[i][31]};
            q.rdv[i] = {p.rdv[i][30:0], 1'b0};
            if (rsh >= {1'b0, p.n})
            begin
                q.rrem[i] = 33'(rsh - {1'b0, p.n});
                q.rq[i]   = {p.rq[i][30:0], 1'b1};
            end
            else
            begin
                q.rrem[i] = rsh[32:0];
                q.rq[i]   = {p.rq[i][30:0], 1'b0};
            end
        end
        return q;
    endfunction

    logic [NSTG-1:0] vld_reg;
    fdiv_t  stage_in;
    fdiv_t  stage_reg [0:FDIV_STEPS-1];
    fdiv_t  last;
    fmul_t  mul_next, mul_reg;
    force_t out_next, out_reg;

    always_comb
    begin
        stage_in     = '0;
        stage_in.e   = in_gain.e;
        stage_in.n   = in_gain.n;
        stage_in.tdv = in_gain.t;
        for (int i = 0; i < DIM; i++)
        begin
            stage_in.rdv[i]  = {in_gain.e.mag[i][1:0], 30'd0};
            stage_in.rrem[i] = {3'd0, in_gain.e.mag[i][31:2]};
        end
    end

    for (genvar g = 0; g < FDIV_STEPS; g++)
    begin : g_step
        fdiv_t stage_next;
        if (g == 0)
        begin : g_first
            assign stage_next = fdiv_step(stage_in);
        end
        else
        begin : g_rest
            assign stage_next = fdiv_step(stage_reg[g-1]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[g] <= stage_next;
            end
        end
    end

    assign last = stage_reg[FDIV_STEPS-1];

    always_comb
    begin
        logic [63:0] pr;
        mul_next.degen = last.e.degen;
        mul_next.neg   = last.e.neg;
        for (int i = 0; i < DIM; i++)
        begin
            pr = {32'd0, last.rq[i]} * {32'd0, last.hq};
            mul_next.mag[i] = pr[63:30];
        end
    end

    always_comb
    begin
        logic [33:0] ng;
        out_next.degen = mul_reg.degen;
        for (int i = 0; i < DIM; i++)
        begin
            ng = 34'd0 - mul_reg.mag[i];
            if (mul_reg.degen)
            begin
                out_next.frc[i] = '0;
            end
            else if (mul_reg.neg[i])
            begin
                out_next.frc[i] = (mul_reg.mag[i] > 34'h080000000) ? 32'h80000000 : ng[31:0];
            end
            else
            begin
                out_next.frc[i] = (mul_reg.mag[i] > 34'h07FFFFFFF) ? 32'h7FFFFFFF
                                                                   : mul_reg.mag[i][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_force = out_reg;

endmodule

// ===== sv/saf_checker.sv =====
// ----------------------------------------------------------------------------
// saf_checker
// port-level checks of the attraction force pipeline
// ----------------------------------------------------------------------------
`include "sigmoid_attraction_force_defines.svh"

module saf_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    `SAF_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input blocked with empty output")
    `SAF_ASSERT_IMP(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    `SAF_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser, m_tdata == 128'd0, "degenerate force not zero")
    `SAF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind sigmoid_attraction_force saf_checker u_saf_checker (.*);

// ===== test/sigmoid_attraction_force_tb.sv =====
// ----------------------------------------------------------------------------
// sigmoid_attraction_force_tb
// drives edge requests with random idling on both sides, predicts each force
// vector with a fixed-point model of the kernel and checks results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sigmoid_attraction_force_tb;
    import saf_pkg::*;

    typedef struct {
        logic [3:0][31:0] fv;
        logic             degen;
    } force_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_wen;
    logic [15:0]  cfg_wdata;

    logic [15:0]  scale_q;
    force_res_t   force_q[$];
    int           err_cnt;
    int           send_idle_pct;
    int           recv_stall_pct;
    longint       cyc;

    sigmoid_attraction_force dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > 4000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] exp_neg_q16(input logic [63:0] x);
        logic [63:0] ip;
        logic [63:0] j;
        logic [63:0] r;
        logic [63:0] ef;
        ip = x >> 16;
        if (ip >= 12)
            return 0;
        j = (x & 64'hFFFF) >> 12;
        r = x & 64'hFFF;
        ef = 64'(EXP_FRAC[j]) - (((64'(EXP_FRAC[j]) - 64'(EXP_FRAC[j + 1])) * r) >> 12);
        return (64'(EXP_INT[ip]) * ef) >> 16;
    endfunction

    function automatic force_res_t attraction(input logic [319:0] req);
        force_res_t  o;
        longint      d[4];
        logic [63:0] m[4];
        logic [63:0] sumsq, n, a, x, s, h, w, ec, nc, t, r, mg, p;
        int          k;
        bit          any;
        k = 0;
        any = 0;
        sumsq = 0;
        o.fv = '0;
        o.degen = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            d[i] = longint'($signed(req[128 + 32*i +: 32])) - longint'($signed(req[32*i +: 32]));
            m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            if (m[i] != 0)
                any = 1;
            if (m[i] >= 64'h80000000)
                k = 1;
        end
        if (!any)
        begin
            o.degen = 1'b1;
            return o;
        end
        for (int i = 0; i < 4; i++)
        begin
            t = m[i] >> k;
            sumsq += t * t;
        end
        n = root64(sumsq) << k;
        w = req[287:256];
        ec = req[303:288];
        nc = req[319:304];
        if (ec == 0)
            ec = 1;
        if (nc == 0)
            nc = 1;
        a = w / ec;
        if (scale_q == 0 || a == 0 || n == 0)
            x = 0;
        else if (n > 64'hFFFFFFFFFFFFFFFF / a)
            x = 64'(X_CAP);
        else
        begin
            p = (n * a) >> 16;
            x = (p * 64'(scale_q)) >> 8;
            if (x > 64'(X_CAP))
                x = 64'(X_CAP);
        end
        s = 64'h100000000 / (64'd65536 + exp_neg_q16(x));
        h = ((s * w) >> 16) / nc;
        for (int i = 0; i < 4; i++)
        begin
            r = (m[i] << 30) / n;
            mg = (r * h) >> 30;
            if (d[i] < 0)
            begin
                if (mg > 64'h80000000)
                    mg = 64'h80000000;
                o.fv[i] = 32'(64'h100000000 - mg);
            end
            else
            begin
                if (mg > 64'h7FFFFFFF)
                    mg = 64'h7FFFFFFF;
                o.fv[i] = mg[31:0];
            end
        end
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        force_res_t exp_r;
        if (m_tvalid && m_tready)
        begin
            if (force_q.size() == 0)
            begin
                $display("%0t unexpected result %h %b", $time, m_tdata, m_tuser);
                err_cnt++;
            end
            else
            begin
                exp_r = force_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[32*i +: 32] !== exp_r.fv[i])
                    begin
                        $display("%0t force_x%0d expected %h actual %h", $time, i,
                                 exp_r.fv[i], m_tdata[32*i +: 32]);
                        err_cnt++;
                    end
                if (m_tuser !== exp_r.degen)
                begin
                    $display("%0t degenerate expected %b actual %b", $time,
                             exp_r.degen, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_edge(input logic [319:0] req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        force_q.push_back(attraction(req));
        @(negedge clk);
    endtask

    task automatic drain_and_set_scale(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (force_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        scale_q = v;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [319:0] make_edge(input logic [31:0] pv[4],
                                               input logic [31:0] pu[4],
                                               input logic [31:0] w,
                                               input logic [15:0] ec,
                                               input logic [15:0] nc);
        logic [319:0] req;
        for (int i = 0; i < 4; i++)
        begin
            req[32*i +: 32] = pv[i];
            req[128 + 32*i +: 32] = pu[i];
        end
        req[287:256] = w;
        req[303:288] = ec;
        req[319:304] = nc;
        return req;
    endfunction

    function automatic logic [31:0] rand_pos(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
            default: return $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] pv[4];
        logic [31:0] pu[4];
        pv = '{default: 32'h00010000};
        pu = pv;
        send_edge(make_edge(pv, pu, 32'h00010000, 16'd1, 16'd1));
        pv = '{default: 32'h80000000};
        pu = '{default: 32'h7FFFFFFF};
        send_edge(make_edge(pv, pu, 32'hFFFFFFFF, 16'd1, 16'd1));
        send_edge(make_edge(pu, pv, 32'hFFFFFFFF, 16'd0, 16'd0));
        send_edge(make_edge(pu, pv, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
        pv = '{default: 32'h0};
        pu = '{32'h00030000, 32'h00040000, 32'h0, 32'h0};
        send_edge(make_edge(pv, pu, 32'h00010000, 16'd1, 16'd1));
        send_edge(make_edge(pu, pv, 32'h00000000, 16'd3, 16'd2));
        send_edge(make_edge(pv, pu, 32'h00000001, 16'd1, 16'd1));
        pu = '{32'h0, 32'h0, 32'h0, 32'h1};
        send_edge(make_edge(pv, pu, 32'h00020000, 16'd1, 16'd1));
        pu = '{32'hFFFFFFFF, 32'h0, 32'h0, 32'h0};
        send_edge(make_edge(pv, pu, 32'h00008000, 16'd2, 16'd0));
        pu = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        send_edge(make_edge(pv, pu, 32'h7FFFFFFF, 16'd1, 16'd1));
        pu = '{32'h00000100, 32'hFFFFFF00, 32'h00000001, 32'hFFFFFFFF};
        send_edge(make_edge(pv, pu, 32'hFFFFFFFF, 16'd1, 16'd1));
    endtask

    task automatic test_random(input int count);
        logic [31:0] pv[4];
        logic [31:0] pu[4];
        logic [31:0] w;
        int          mode;
        for (int j = 0; j < count; j++)
        begin
            mode = $urandom_range(2);
            for (int i = 0; i < 4; i++)
            begin
                pv[i] = rand_pos(mode);
                pu[i] = rand_pos(mode);
            end
            if ($urandom_range(19) == 0)
                pu = pv;
            w = $urandom_range(1) ? $urandom() : $urandom_range(0, 32'h0004FFFF);
            send_edge(make_edge(pv, pu, w, 16'($urandom_range(0, 65535)),
                                $urandom_range(3) == 0 ? 16'($urandom()) :
                                16'($urandom_range(0, 8))));
        end
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(300);
        send_idle_pct = 60;
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        test_random(250);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_scales();
        drain_and_set_scale(16'd0);
        test_random(80);
        drain_and_set_scale(16'hFFFF);
        test_random(80);
        drain_and_set_scale(16'd1);
        test_random(60);
        drain_and_set_scale(16'($urandom()));
        test_random(60);
        drain_and_set_scale(SCALE_RESET);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        scale_q = SCALE_RESET;
        err_cnt = 0;
        cyc = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_idle_phases();
        test_scales();
        while (force_q.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
